### rtl/core/assert_macros.svh
// assertion macros shared by the transcoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/u2u8_pkg.sv
// shared types, constants and utf-8 encode helpers for the transcoder
package u2u8_pkg;

  localparam int UnitW      = 16;
  localparam int CpW        = 21;
  localparam int QueueDepth = 2;

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [CpW-1:0]   SuppBase  = 21'h10000;

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // work handed from front to back: an optional held-surrogate flush, then
  // an optional code point
  typedef struct packed {
    logic           flush;
    logic [9:0]     flush_bits;
    logic           emit;
    logic [CpW-1:0] cp;
    logic           fin;
  } job_t;

  function automatic logic [2:0] byte_count(input logic [CpW-1:0] cp);
    logic [2:0] n;
    if (cp < 21'h80)         n = Len1;
    else if (cp < 21'h800)   n = Len2;
    else if (cp < 21'h10000) n = Len3;
    else                     n = Len4;
    return n;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [CpW-1:0] cp,
                                          input logic [2:0]     len,
                                          input logic [1:0]     idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      Len1: b = {1'b0, cp[6:0]};
      Len2: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      Len3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

### rtl/core/u2u8_ifs.sv
// valid/ready channel interfaces for code units in and utf-8 bytes out
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

### rtl/core/utf16_to_utf8_transcoder.sv
// top level of the utf-16 to utf-8 transcoder
//
//   channel   dir   payload                           role
//   in_chan   in    code_unit[15:0], final_unit       one utf-16 code unit per transfer
//   out_chan  out   out_byte[7:0], run_end, string_end one utf-8 byte per transfer
//
// one output byte leaves per cycle from the single output register while jobs are
// queued and out_chan is not stalled; a unit causes 0 bytes (held high surrogate),
// 1 to 4, or up to 6 when a held surrogate is flushed ahead of the unit.
// in_chan takes a new unit every cycle while the job queue has room
// (QUEUE_DEPTH jobs), so bursts of short units run back to back.
// rst_n is synchronous, active low: clears held surrogate, queue and output valid.
// a stall on out_chan backs up into the queue, then drops in_chan.ready.

module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u2u8_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  u2u8_in_if.sink     in_chan,
  u2u8_out_if.source  out_chan
);

  // jobs from the classifier to the byte sequencer
  u2u8_pkg::job_t push_job, head_job;
  logic           q_push, q_full, q_pop, q_empty;

  // front: surrogate pairing and job build
  u2u8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  // decoupling queue so either side can stall on its own
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // back: utf-8 byte sequencer with registered output
  u2u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

### rtl/core/u2u8_front.sv
// front end: accepts code units, tracks a held high surrogate, builds jobs
`include "assert_macros.svh"

module u2u8_front (
  input  logic              clk,
  input  logic              rst_n,
  u2u8_in_if.sink           in_chan,
  input  logic              q_full,
  output logic              q_push,
  output u2u8_pkg::job_t    q_job
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [9:0] pend_bits_r,  pend_bits_nxt;
  logic       accept, is_high, is_low;
  logic [15:0] u;

  assign u       = in_chan.code_unit;
  assign is_high = (u >= u2u8_pkg::HighFirst) && (u <= u2u8_pkg::HighLast);
  assign is_low  = (u >= u2u8_pkg::LowFirst)  && (u <= u2u8_pkg::LowLast);

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    q_job          = '0;
    q_job.fin      = in_chan.final_unit;
    pend_valid_nxt = pend_valid_r;
    pend_bits_nxt  = pend_bits_r;
    if (pend_valid_r && is_low) begin
      q_job.emit     = 1'b1;
      q_job.cp       = u2u8_pkg::SuppBase + {1'b0, pend_bits_r, u[9:0]};
      pend_valid_nxt = 1'b0;
    end else begin
      q_job.flush      = pend_valid_r;
      q_job.flush_bits = pend_bits_r;
      if (is_high && !in_chan.final_unit) begin
        pend_valid_nxt = 1'b1;
        pend_bits_nxt  = u[9:0];
      end else begin
        q_job.emit     = 1'b1;
        q_job.cp       = {5'd0, u};
        pend_valid_nxt = 1'b0;
      end
    end
  end

  assign q_push = accept && (q_job.flush || q_job.emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_bits_r  <= '0;
    end else if (accept) begin
      pend_valid_r <= pend_valid_nxt;
      pend_bits_r  <= pend_bits_nxt;
    end
  end

  // a final unit always leaves nothing held
  `ASSERT_NEXT(a_final_clears, accept && in_chan.final_unit, !pend_valid_r, "held unit after final")

endmodule

### rtl/core/u2u8_queue.sv
// small job queue between front and back
`include "assert_macros.svh"

module u2u8_queue #(
  parameter int DEPTH = u2u8_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u2u8_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output u2u8_pkg::job_t head_job,
  output logic           empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  u2u8_pkg::job_t  slots [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full     = (count_r == FullCnt);
  assign empty    = (count_r == '0);
  assign head_job = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
  `ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

### rtl/core/u2u8_back.sv
// back end: walks each job one utf-8 byte per cycle into the output register while out_chan is not stalled
`include "assert_macros.svh"

module u2u8_back (
  input  logic           clk,
  input  logic           rst_n,
  input  u2u8_pkg::job_t head_job,
  input  logic           q_empty,
  output logic           q_pop,
  u2u8_out_if.source     out_chan
);

  logic       main_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       run_end_r, string_end_r;

  logic                     in_flush, last_part, last_job, step;
  logic [u2u8_pkg::CpW-1:0] cur_cp;
  logic [2:0]               cur_len;
  logic [7:0]               cur_byte;

  assign in_flush  = head_job.flush && !main_r;
  assign cur_cp    = in_flush ? {5'd0, 6'b110110, head_job.flush_bits} : head_job.cp;
  assign cur_len   = in_flush ? u2u8_pkg::Len3 : u2u8_pkg::byte_count(head_job.cp);
  assign cur_byte  = u2u8_pkg::enc_byte(cur_cp, cur_len, idx_r);
  assign last_part = ({1'b0, idx_r} == cur_len - 3'd1);
  assign last_job  = last_part && (!in_flush || !head_job.emit);
  assign step      = !q_empty && (!valid_r || out_chan.ready);
  assign q_pop     = step && last_job;

  assign out_chan.valid      = valid_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.run_end    = run_end_r;
  assign out_chan.string_end = string_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      main_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (step) begin
        valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        valid_r <= 1'b0;
      end
      if (step) begin
        if (last_job) begin
          main_r <= 1'b0;
          idx_r  <= '0;
        end else if (last_part) begin
          main_r <= 1'b1;
          idx_r  <= '0;
        end else begin
          idx_r  <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r       <= cur_byte;
      run_end_r    <= last_job;
      string_end_r <= last_job && head_job.fin;
    end
  end

  // byte index never runs past the length of the sequence being sent
  `ASSERT_IMPL(a_idx_in_range, !q_empty, {1'b0, idx_r} < cur_len, "byte index overrun")

endmodule
